/* hdl/atp_pkg.sv */
package atp_pkg;

    // Pipeline shape
    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int SQRT_STAGES     = 16;
    localparam int ACC_FRAC        = 16;
    localparam int ACC_SH          = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int AXIS_LAT        = SQRT_STAGES + CORDIC_STAGES + 1;

    // Datapath widths
    localparam int XY_W   = 36;
    localparam int Z_W    = 26;
    localparam int ANG_W  = ANGLE_FRAC_BITS + 8;
    localparam int BL_W   = 40;

    localparam logic signed [ANG_W-1:0] ANG_LIM =
        ANG_W'(90 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [BL_W-1:0] FUSE_LIM =
        BL_W'(180 * (1 << ANGLE_FRAC_BITS));

    // Register indexes
    typedef enum logic [1:0] {
        REG_BLEND_WEIGHT     = 2'd0,
        REG_MOTION_THRESHOLD = 2'd1
    } cfg_index_t;

    // Per-item side data carried beside the angle pipelines
    typedef struct packed {
        logic signed [16:0] groll;
        logic signed [16:0] gpitch;
        logic               still_roll;
        logic               still_pitch;
    } side_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = Z_W'(2949120);
            1:       v = Z_W'(1740967);
            2:       v = Z_W'(919879);
            3:       v = Z_W'(466945);
            4:       v = Z_W'(234379);
            5:       v = Z_W'(117304);
            6:       v = Z_W'(58666);
            7:       v = Z_W'(29335);
            8:       v = Z_W'(14668);
            9:       v = Z_W'(7334);
            10:      v = Z_W'(3667);
            11:      v = Z_W'(1833);
            12:      v = Z_W'(917);
            13:      v = Z_W'(458);
            14:      v = Z_W'(229);
            15:      v = Z_W'(115);
            16:      v = Z_W'(57);
            17:      v = Z_W'(29);
            18:      v = Z_W'(14);
            19:      v = Z_W'(7);
            20:      v = Z_W'(4);
            21:      v = Z_W'(2);
            22:      v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/atp_tilt_axis.sv */
module atp_tilt_axis (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [15:0]                num,
    input  logic [31:0]                       sum_sq,
    output logic signed [atp_pkg::ANG_W-1:0]  angle
);
    import atp_pkg::*;

    // Root stages, one result bit each
    logic [31:0]        sq_n_reg   [SQRT_STAGES];
    logic [31:0]        sq_res_reg [SQRT_STAGES];
    logic signed [15:0] sq_num_reg [SQRT_STAGES];
    logic [31:0]        sq_n_next   [SQRT_STAGES];
    logic [31:0]        sq_res_next [SQRT_STAGES];

    always_comb
    begin
        logic [31:0] n_in;
        logic [31:0] r_in;
        logic [31:0] bitv;
        logic [32:0] trial;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            n_in  = (k == 0) ? sum_sq : sq_n_reg[(k == 0) ? 0 : k - 1];
            r_in  = (k == 0) ? 32'd0  : sq_res_reg[(k == 0) ? 0 : k - 1];
            bitv  = 32'd1 << (30 - 2 * k);
            trial = {1'b0, r_in} + {1'b0, bitv};
            if ({1'b0, n_in} >= trial)
            begin
                sq_n_next[k]   = n_in - trial[31:0];
                sq_res_next[k] = (r_in >> 1) + bitv;
            end
            else
            begin
                sq_n_next[k]   = n_in;
                sq_res_next[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                sq_n_reg[k]   <= sq_n_next[k];
                sq_res_reg[k] <= sq_res_next[k];
                sq_num_reg[k] <= (k == 0) ? num : sq_num_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Vectoring rotation stages
    logic signed [XY_W-1:0] cx_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0] cy_reg [CORDIC_STAGES];
    logic signed [Z_W-1:0]  cz_reg [CORDIC_STAGES];
    logic                   cnull_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0] cx_next [CORDIC_STAGES];
    logic signed [XY_W-1:0] cy_next [CORDIC_STAGES];
    logic signed [Z_W-1:0]  cz_next [CORDIC_STAGES];
    logic                   cnull_next;
    logic signed [XY_W-1:0] x0;
    logic signed [XY_W-1:0] y0;

    assign x0 = XY_W'(signed'({1'b0, sq_res_reg[SQRT_STAGES-1][15:0], 16'd0}));
    assign y0 = XY_W'(signed'({sq_num_reg[SQRT_STAGES-1], 16'd0}));
    assign cnull_next = (sq_num_reg[SQRT_STAGES-1] == 16'sd0)
                     && (sq_res_reg[SQRT_STAGES-1] == 32'd0);

    always_comb
    begin
        logic signed [XY_W-1:0] xi;
        logic signed [XY_W-1:0] yi;
        logic signed [Z_W-1:0]  zi;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xi = (i == 0) ? x0 : cx_reg[(i == 0) ? 0 : i - 1];
            yi = (i == 0) ? y0 : cy_reg[(i == 0) ? 0 : i - 1];
            zi = (i == 0) ? '0 : cz_reg[(i == 0) ? 0 : i - 1];
            if (!yi[XY_W-1])
            begin
                cx_next[i] = xi + (yi >>> i);
                cy_next[i] = yi - (xi >>> i);
                cz_next[i] = zi + atan_entry(i);
            end
            else
            begin
                cx_next[i] = xi - (yi >>> i);
                cy_next[i] = yi + (xi >>> i);
                cz_next[i] = zi - atan_entry(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                cx_reg[i]    <= cx_next[i];
                cy_reg[i]    <= cy_next[i];
                cz_reg[i]    <= cz_next[i];
                cnull_reg[i] <= (i == 0) ? cnull_next : cnull_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // Round to output resolution and clamp to a quarter turn
    logic signed [Z_W-1:0]   z_rnd;
    logic signed [ANG_W-1:0] angle_reg;
    logic signed [ANG_W-1:0] angle_next;

    always_comb
    begin
        z_rnd = (cz_reg[CORDIC_STAGES-1] + (Z_W'(1) <<< (ACC_SH - 1))) >>> ACC_SH;
        if (cnull_reg[CORDIC_STAGES-1])
            angle_next = '0;
        else if (z_rnd > Z_W'(ANG_LIM))
            angle_next = ANG_LIM;
        else if (z_rnd < -Z_W'(ANG_LIM))
            angle_next = -ANG_LIM;
        else
            angle_next = z_rnd[ANG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

/* hdl/accel_tilt_complementary_fusion.sv */
// Accelerometer tilt with complementary fusion.
//
// Input channel: one item per accepted in_valid/!in_stall carries three
// accelerometer axes, two gyro-integrated angles and two gyro rates.
// Output channel: one item per input, accel roll/pitch and fused roll/pitch,
// all angles in 1/256 degree.
// Config: cfg_we with cfg_index 0 = blend weight (Q1.15), 1 = motion
// threshold; other indexes are ignored. Write only while idle.
//
// Throughput: one item per cycle while no valid output is stalled.
// Pipeline from acceptance to out_valid: three input stages, the 16
// root stages, one CORDIC stage per rotation, a rounding stage and two
// blend stages.
// Reset clears all valid bits and loads the default register values.
// When the receiver stalls a valid output, the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
module accel_tilt_complementary_fusion (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [16:0] gyro_roll_angle,
    input  logic signed [16:0] gyro_pitch_angle,
    input  logic signed [19:0] roll_rate,
    input  logic signed [19:0] pitch_rate,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] accel_roll,
    output logic signed [15:0] accel_pitch,
    output logic signed [16:0] fused_roll,
    output logic signed [16:0] fused_pitch,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);
    import atp_pkg::*;

    // Configuration registers
    logic [15:0] blend_weight_reg;
    logic [15:0] motion_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_weight_reg     <= 16'd32113;
            motion_threshold_reg <= 16'd26;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLEND_WEIGHT:     blend_weight_reg     <= cfg_wdata;
                REG_MOTION_THRESHOLD: motion_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Global advance
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Valid line
    localparam int VLEN = AXIS_LAT + 5;
    logic [VLEN-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[VLEN-2:0], in_valid};
    end
    assign out_valid = v_reg[VLEN-1];

    // Stage 1: capture item
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [16:0] gr_reg, gp_reg;
    logic signed [19:0] rr_reg, rp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gr_reg <= gyro_roll_angle;
            gp_reg <= gyro_pitch_angle;
            rr_reg <= roll_rate;
            rp_reg <= pitch_rate;
        end
    end

    // Stage 2: squares and motion test
    logic [31:0]        sqx_reg, sqy_reg, sqz_reg;
    logic signed [15:0] ax2_reg, ay2_reg;
    side_t              side2_reg;
    side_t              side2_next;
    logic [19:0]        mag_r, mag_p;

    always_comb
    begin
        mag_r = rr_reg[19] ? 20'(-rr_reg) : 20'(rr_reg);
        mag_p = rp_reg[19] ? 20'(-rp_reg) : 20'(rp_reg);
        side2_next.groll       = gr_reg;
        side2_next.gpitch      = gp_reg;
        side2_next.still_roll  = mag_r < {4'd0, motion_threshold_reg};
        side2_next.still_pitch = mag_p < {4'd0, motion_threshold_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg   <= 32'(ax_reg * ax_reg);
            sqy_reg   <= 32'(ay_reg * ay_reg);
            sqz_reg   <= 32'(az_reg * az_reg);
            ax2_reg   <= ax_reg;
            ay2_reg   <= ay_reg;
            side2_reg <= side2_next;
        end
    end

    // Stage 3: sums of squares
    logic [31:0]        sxz_reg, syz_reg;
    logic signed [15:0] ax3_reg, ay3_reg;
    side_t              side3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxz_reg   <= sqx_reg + sqz_reg;
            syz_reg   <= sqy_reg + sqz_reg;
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            side3_reg <= side2_reg;
        end
    end

    // Angle pipelines
    logic signed [ANG_W-1:0] roll_ang, pitch_raw;

    atp_tilt_axis u_roll (
        .clk    (clk),
        .en     (en),
        .num    (ay3_reg),
        .sum_sq (sxz_reg),
        .angle  (roll_ang)
    );

    atp_tilt_axis u_pitch (
        .clk    (clk),
        .en     (en),
        .num    (ax3_reg),
        .sum_sq (syz_reg),
        .angle  (pitch_raw)
    );

    // Side data delay matching the angle pipelines
    side_t side_dl_reg [AXIS_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < AXIS_LAT; k++)
                side_dl_reg[k] <= (k == 0) ? side3_reg : side_dl_reg[(k == 0) ? 0 : k - 1];
        end
    end

    // Blend stage 1: weight products
    logic signed [17:0]      alpha;
    logic signed [17:0]      beta;
    logic signed [ANG_W-1:0] pitch_ang;
    logic signed [BL_W-1:0]  pgr_reg, par_reg, pgp_reg, pap_reg;
    logic signed [ANG_W-1:0] roll_b_reg, pitch_b_reg;
    logic                    still_r_reg, still_p_reg;
    side_t                   side_end;

    always_comb
    begin
        side_end  = side_dl_reg[AXIS_LAT-1];
        pitch_ang = -pitch_raw;
        alpha     = (blend_weight_reg > 16'd32768) ? 18'sd32768
                                                   : signed'({2'b00, blend_weight_reg});
        beta      = 18'sd32768 - alpha;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pgr_reg     <= BL_W'(alpha * side_end.groll);
            pgp_reg     <= BL_W'(alpha * side_end.gpitch);
            par_reg     <= BL_W'(beta * roll_ang);
            pap_reg     <= BL_W'(beta * pitch_ang);
            roll_b_reg  <= roll_ang;
            pitch_b_reg <= pitch_ang;
            still_r_reg <= side_end.still_roll;
            still_p_reg <= side_end.still_pitch;
        end
    end

    // Blend stage 2: sum, round, clamp (or take the accel angle when still) into output register
    logic signed [BL_W-1:0] sr, sp, fr, fp;
    logic signed [15:0]     acc_roll_next, acc_pitch_next;
    logic signed [16:0]     fused_roll_next, fused_pitch_next;
    logic signed [15:0]     acc_roll_reg, acc_pitch_reg;
    logic signed [16:0]     fused_roll_reg, fused_pitch_reg;

    always_comb
    begin
        sr = (pgr_reg + par_reg + BL_W'(16384)) >>> 15;
        sp = (pgp_reg + pap_reg + BL_W'(16384)) >>> 15;
        if (sr > FUSE_LIM)
            fr = FUSE_LIM;
        else if (sr < -FUSE_LIM)
            fr = -FUSE_LIM;
        else
            fr = sr;
        if (sp > FUSE_LIM)
            fp = FUSE_LIM;
        else if (sp < -FUSE_LIM)
            fp = -FUSE_LIM;
        else
            fp = sp;
        if (still_r_reg)
            fr = BL_W'(roll_b_reg);
        if (still_p_reg)
            fp = BL_W'(pitch_b_reg);
        acc_roll_next    = 16'(roll_b_reg);
        acc_pitch_next   = 16'(pitch_b_reg);
        fused_roll_next  = fr[16:0];
        fused_pitch_next = fp[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_roll_reg    <= acc_roll_next;
            acc_pitch_reg   <= acc_pitch_next;
            fused_roll_reg  <= fused_roll_next;
            fused_pitch_reg <= fused_pitch_next;
        end
    end

    assign accel_roll  = acc_roll_reg;
    assign accel_pitch = acc_pitch_reg;
    assign fused_roll  = fused_roll_reg;
    assign fused_pitch = fused_pitch_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import atp_pkg::*;

    localparam int LATENCY   = 38;
    localparam int N_RANDOM  = 1330;

    // One input item
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [16:0] groll;
        logic signed [16:0] gpitch;
        logic signed [19:0] rroll;
        logic signed [19:0] rpitch;
    } imu_item_t;

    // One result item
    typedef struct packed {
        logic signed [15:0] aroll;
        logic signed [15:0] apitch;
        logic signed [16:0] froll;
        logic signed [16:0] fpitch;
    } tilt_item_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [16:0] gyro_roll_angle;
    logic signed [16:0] gyro_pitch_angle;
    logic signed [19:0] roll_rate;
    logic signed [19:0] pitch_rate;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] accel_roll;
    logic signed [15:0] accel_pitch;
    logic signed [16:0] fused_roll;
    logic signed [16:0] fused_pitch;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_wdata;

    imu_item_t  pending_imu[$];
    tilt_item_t expected_tilt[$];
    logic [15:0] alpha_q15;
    logic [15:0] still_limit;
    int          n_errors = 0;
    int          n_checked = 0;
    int          n_sent = 0;
    int          send_gap;
    int          stall_left;

    accel_tilt_complementary_fusion dut (.*);

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Integer square root, floor
    function automatic longint root_floor(input logic [31:0] n);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Vectoring rotation for atan2(num, den), den >= 0; 1/256 degree out
    function automatic longint tilt_angle(input longint num, input longint den);
        longint x, y, z, xs, ys;
        if (num == 0 && den == 0)
            return 0;
        x = den * 65536;
        y = num * 65536;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_entry(i));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_entry(i));
            end
        end
        z = (z + (64'sd1 <<< (ACC_SH - 1))) >>> ACC_SH;
        if (z > 90 * 256) z = 90 * 256;
        if (z < -90 * 256) z = -90 * 256;
        return z;
    endfunction

    // Complementary blend of one axis
    function automatic longint fuse_axis(input longint acc, input longint gyro,
                                         input longint rate);
        longint a, mag, s;
        mag = rate < 0 ? -rate : rate;
        if (mag < longint'(still_limit))
            return acc;
        a = longint'(alpha_q15);
        if (a > 32768) a = 32768;
        s = (a * gyro + (32768 - a) * acc + 16384) >>> 15;
        if (s > 180 * 256) s = 180 * 256;
        if (s < -180 * 256) s = -180 * 256;
        return s;
    endfunction

    function automatic tilt_item_t predict_tilt(input imu_item_t it);
        tilt_item_t r;
        longint ax, ay, az, roll, pitch;
        logic [31:0] sxz, syz;
        ax = it.ax;
        ay = it.ay;
        az = it.az;
        sxz = 32'(ax * ax) + 32'(az * az);
        syz = 32'(ay * ay) + 32'(az * az);
        roll  = tilt_angle(ay, root_floor(sxz));
        pitch = -tilt_angle(ax, root_floor(syz));
        r.aroll  = 16'(roll);
        r.apitch = 16'(pitch);
        r.froll  = 17'(fuse_axis(roll, it.groll, it.rroll));
        r.fpitch = 17'(fuse_axis(pitch, it.gpitch, it.rpitch));
        return r;
    endfunction

    function automatic imu_item_t random_imu();
        imu_item_t it;
        it = imu_item_t'({$urandom, $urandom, $urandom, $urandom});
        // mostly realistic gyro angles, rates near the threshold now and then
        if ($urandom_range(0, 3) != 0)
        begin
            it.groll  = 17'($signed($urandom_range(0, 92160)) - 46080);
            it.gpitch = 17'($signed($urandom_range(0, 92160)) - 46080);
        end
        if ($urandom_range(0, 2) == 0)
            it.rroll = 20'($signed($urandom_range(0, 80)) - 40);
        if ($urandom_range(0, 2) == 0)
            it.rpitch = 20'($signed($urandom_range(0, 80)) - 40);
        if ($urandom_range(0, 7) == 0)
            it.az = 0;
        return it;
    endfunction

    function automatic imu_item_t make_imu(input int ax, input int ay, input int az,
                                           input int gr, input int gp,
                                           input int rr, input int rp);
        imu_item_t it;
        it.ax = 16'(ax);
        it.ay = 16'(ay);
        it.az = 16'(az);
        it.groll  = 17'(gr);
        it.gpitch = 17'(gp);
        it.rroll  = 20'(rr);
        it.rpitch = 20'(rp);
        return it;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BLEND_WEIGHT)
            alpha_q15 = val;
        else
            still_limit = val;
    endtask

    // Write to an index the block does not decode; must be ignored
    task automatic write_unused_index();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= 2'd3;
        cfg_wdata <= 16'hFFFF;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_imu.size() != 0 || expected_tilt.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid         <= 1'b0;
            send_gap         <= 0;
            accel_x          <= '0;
            accel_y          <= '0;
            accel_z          <= '0;
            gyro_roll_angle  <= '0;
            gyro_pitch_angle <= '0;
            roll_rate        <= '0;
            pitch_rate       <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_tilt.push_back(predict_tilt(pending_imu.pop_front()));
                n_sent++;
            end
            if (in_valid && in_stall)
                ;
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_imu.size() != 0)
            begin
                imu_item_t nx;
                nx = pending_imu[0];
                in_valid         <= 1'b1;
                accel_x          <= nx.ax;
                accel_y          <= nx.ay;
                accel_z          <= nx.az;
                gyro_roll_angle  <= nx.groll;
                gyro_pitch_angle <= nx.gpitch;
                roll_rate        <= nx.rroll;
                pitch_rate       <= nx.rpitch;
                send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                tilt_item_t exp_t;
                if (expected_tilt.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time,
                             {accel_roll, accel_pitch, fused_roll, fused_pitch});
                    n_errors++;
                end
                else
                begin
                    exp_t = expected_tilt.pop_front();
                    n_checked++;
                    if (accel_roll !== exp_t.aroll)
                    begin
                        $display("%0t: accel_roll exp %0d got %0d", $time,
                                 exp_t.aroll, accel_roll);
                        n_errors++;
                    end
                    if (accel_pitch !== exp_t.apitch)
                    begin
                        $display("%0t: accel_pitch exp %0d got %0d", $time,
                                 exp_t.apitch, accel_pitch);
                        n_errors++;
                    end
                    if (fused_roll !== exp_t.froll)
                    begin
                        $display("%0t: fused_roll exp %0d got %0d", $time,
                                 exp_t.froll, fused_roll);
                        n_errors++;
                    end
                    if (fused_pitch !== exp_t.fpitch)
                    begin
                        $display("%0t: fused_pitch exp %0d got %0d", $time,
                                 exp_t.fpitch, fused_pitch);
                        n_errors++;
                    end
                end
            end
            // per-item stall draw, with long calm stretches
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (out_valid && !out_stall && $urandom_range(0, 3) == 0)
            begin
                stall_left <= $urandom_range(0, 14);
                out_stall  <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Stimulus
    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        alpha_q15   = 16'd32113;
        still_limit = 16'd26;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, zero vector, thresholds, gyro beyond range
        pending_imu.push_back(make_imu(0, 0, 0, 0, 0, 0, 0));
        pending_imu.push_back(make_imu(0, 0, 0, 46080, -46080, 524287, -524288));
        pending_imu.push_back(make_imu(-32768, -32768, -32768, 0, 0, 25, 26));
        pending_imu.push_back(make_imu(32767, 32767, 32767, -46080, 46080, -26, -25));
        pending_imu.push_back(make_imu(-32768, 32767, 0, 65535, -65536, 1000, -1000));
        pending_imu.push_back(make_imu(32767, -32768, 0, -65536, 65535, -524288, 524287));
        pending_imu.push_back(make_imu(0, 16384, 0, 0, 0, 0, 0));
        pending_imu.push_back(make_imu(16384, 0, 0, 0, 0, 0, 0));
        pending_imu.push_back(make_imu(0, 0, 16384, 100, -100, 500, 500));
        pending_imu.push_back(make_imu(1, -1, 0, 23040, -23040, 30, -30));
        drain();

        // extremes of alpha, threshold at zero; unused index write
        write_reg(REG_BLEND_WEIGHT, 16'hFFFF);
        write_reg(REG_MOTION_THRESHOLD, 16'd0);
        write_unused_index();
        pending_imu.push_back(make_imu(-32768, 32767, -32768, 65535, -65536, 0, 0));
        pending_imu.push_back(make_imu(1000, -2000, 3000, -46080, 46080, -1, 1));
        repeat (4) pending_imu.push_back(random_imu());
        drain();
        write_reg(REG_BLEND_WEIGHT, 16'd0);
        write_reg(REG_MOTION_THRESHOLD, 16'hFFFF);
        pending_imu.push_back(make_imu(500, 500, 500, 46080, 46080, -65535, 65535));
        pending_imu.push_back(make_imu(500, 500, 500, 46080, 46080, -65536, 524287));
        repeat (2) pending_imu.push_back(random_imu());
        drain();

        // random phases under varied settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_BLEND_WEIGHT, 16'd32113);
                         write_reg(REG_MOTION_THRESHOLD, 16'd26); end
                1: begin write_reg(REG_BLEND_WEIGHT, 16'd32768);
                         write_reg(REG_MOTION_THRESHOLD, 16'd1); end
                2: begin write_reg(REG_BLEND_WEIGHT, 16'($urandom_range(0, 32768)));
                         write_reg(REG_MOTION_THRESHOLD, 16'($urandom_range(0, 60))); end
                3: begin write_reg(REG_BLEND_WEIGHT, 16'($urandom_range(32769, 65535)));
                         write_reg(REG_MOTION_THRESHOLD, 16'($urandom)); end
                default: begin write_reg(REG_BLEND_WEIGHT, 16'd16384);
                         write_reg(REG_MOTION_THRESHOLD, 16'd40); end
            endcase
            for (int k = 0; k < N_RANDOM / 5; k++)
                pending_imu.push_back(random_imu());
            drain();
        end

        $display("Checked %0d results from %0d items over seven register settings,",
                 n_checked, n_sent);
        $display("with random input gaps and output stalls; %0d mismatches.", n_errors);
        if (n_errors == 0 && expected_tilt.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Timeout
    initial
    begin
        #(12 * 400000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
